FILE: rtl/core/pwm_voice_allocator_assert.svh
// Assertion macros for the voice allocator.
`ifndef PWM_VOICE_ALLOCATOR_ASSERT_SVH
`define PWM_VOICE_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define PVA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pwm voice allocator: assertion failed");

// Next-cycle implication, checked outside reset.
`define PVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pwm voice allocator: assertion failed");

`else

`define PVA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PVA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/core/pva_pkg.sv
package pva_pkg;

  localparam int NumVoices = 4;

  // Period divider: 1000000 fits in 20 bits, one quotient bit per cycle.
  localparam int DivBits = 20;
  localparam int DivCntW = $clog2(DivBits);
  localparam logic [DivBits-1:0] TickRate = 20'd1000000;

  localparam int TopW = 16;
  localparam int DutyW = 7;
  localparam logic [DutyW-1:0] DutyFull = 7'd100;
  localparam int ProdW = TopW + DutyW;

  // floor(x / 100) as (x * ceil(2^30 / 100)) >> 30, exact for x below 2^23.
  localparam int RecipW = 24;
  localparam int RecipShift = 30;
  localparam logic [RecipW-1:0] RecipMul = 24'd10737419;
  localparam int ScaleW = ProdW + RecipW;

  typedef enum logic {
    OpStart = 1'b0,
    OpStop  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StDivide,
    StMult,
    StScale,
    StCommit
  } state_e;

  typedef struct packed {
    logic load_req;
    logic search;
    logic div_step;
    logic mul;
    logic scale;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic go_divide;
  } sts_t;

endpackage

FILE: rtl/core/pva_req_if.sv
interface pva_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] pitch_hz;
  logic [7:0]  duty_percent;

  modport source (output valid, output opcode, output pitch_hz, output duty_percent,
                  input ready);
  modport sink (input valid, input opcode, input pitch_hz, input duty_percent,
                output ready);
endinterface

FILE: rtl/core/pva_rsp_if.sv
interface pva_rsp_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [1:0]  voice;
  logic [15:0] period_top;
  logic [15:0] compare_value;
  logic        run;

  modport source (output valid, output accepted, output voice, output period_top,
                  output compare_value, output run, input ready);
  modport sink (input valid, input accepted, input voice, input period_top,
                input compare_value, input run, output ready);
endinterface

FILE: rtl/core/pva_ctrl.sv
module pva_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  pva_pkg::sts_t sts_i,
  output pva_pkg::cmd_t cmd_o
);

  localparam logic [pva_pkg::DivCntW-1:0] DivLast = pva_pkg::DivCntW'(pva_pkg::DivBits - 1);

  pva_pkg::state_e state_q, state_d;
  logic [pva_pkg::DivCntW-1:0] div_cnt_q, div_cnt_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pva_pkg::StIdle;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      pva_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = pva_pkg::StSearch;
        end
      end
      pva_pkg::StSearch: begin
        cmd_o.search = 1'b1;
        div_cnt_d    = '0;
        state_d      = sts_i.go_divide ? pva_pkg::StDivide : pva_pkg::StCommit;
      end
      pva_pkg::StDivide: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = div_cnt_q + 1'b1;
        if (div_cnt_q == DivLast) state_d = pva_pkg::StMult;
      end
      pva_pkg::StMult: begin
        cmd_o.mul = 1'b1;
        state_d   = pva_pkg::StScale;
      end
      pva_pkg::StScale: begin
        cmd_o.scale = 1'b1;
        state_d     = pva_pkg::StCommit;
      end
      pva_pkg::StCommit: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = pva_pkg::StIdle;
        end
      end
      default: state_d = pva_pkg::StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/pva_dp.sv
module pva_dp #(
  parameter int NUM_VOICES = pva_pkg::NumVoices
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          opcode_i,
  input  logic [15:0]   pitch_hz_i,
  input  logic [7:0]    duty_percent_i,
  input  pva_pkg::cmd_t cmd_i,
  output pva_pkg::sts_t sts_o,
  output logic          accepted_o,
  output logic [1:0]    voice_o,
  output logic [15:0]   period_top_o,
  output logic [15:0]   compare_value_o,
  output logic          run_o
);

  localparam int IdxW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int DivBits = pva_pkg::DivBits;
  localparam int TopW = pva_pkg::TopW;

  pva_pkg::op_e op_q;
  logic [15:0] hz_q;
  logic [pva_pkg::DutyW-1:0] duty_q;

  logic [NUM_VOICES-1:0] busy_q;
  logic [15:0] pitch_q [NUM_VOICES];

  logic found_q;
  logic [IdxW-1:0] idx_q;
  logic [15:0] rem_q;
  logic [DivBits-1:0] quo_q;
  logic [pva_pkg::ProdW-1:0] prod_q;
  logic [15:0] cmp_q;

  logic [NUM_VOICES-1:0] match;
  logic found_c;
  logic [IdxW-1:0] idx_c;
  logic [16:0] shifted;
  logic [16:0] diff;
  logic ge;
  logic [TopW-1:0] top_c;
  logic [pva_pkg::ScaleW-1:0] scaled;
  logic start_ok;

  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      match[v] = (op_q == pva_pkg::OpStart) ? !busy_q[v] : (busy_q[v] && pitch_q[v] == hz_q);
    end
  end

  // lowest index wins
  always_comb begin
    found_c = 1'b0;
    idx_c   = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (match[v]) begin
        found_c = 1'b1;
        idx_c   = IdxW'(v);
      end
    end
  end

  assign sts_o.go_divide = found_c && (hz_q != '0) && (op_q == pva_pkg::OpStart);

  // restoring division step
  assign shifted = {rem_q, quo_q[DivBits-1]};
  assign diff    = shifted - {1'b0, hz_q};
  assign ge      = (shifted >= {1'b0, hz_q});

  assign top_c  = (|quo_q[DivBits-1:TopW]) ? {TopW{1'b1}} : quo_q[TopW-1:0];
  assign scaled = {{pva_pkg::RecipW{1'b0}}, prod_q} *
                  {{pva_pkg::ProdW{1'b0}}, pva_pkg::RecipMul};
  assign start_ok = found_q && (op_q == pva_pkg::OpStart);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (cmd_i.commit && found_q) begin
      busy_q[idx_q] <= (op_q == pva_pkg::OpStart);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      op_q   <= pva_pkg::op_e'(opcode_i);
      hz_q   <= pitch_hz_i;
      duty_q <= (duty_percent_i > {1'b0, pva_pkg::DutyFull}) ? pva_pkg::DutyFull
                                                            : duty_percent_i[pva_pkg::DutyW-1:0];
    end
    if (cmd_i.search) begin
      found_q <= found_c && (hz_q != '0);
      idx_q   <= idx_c;
      rem_q   <= '0;
      quo_q   <= pva_pkg::TickRate;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[15:0] : shifted[15:0];
      quo_q <= {quo_q[DivBits-2:0], ge};
    end
    if (cmd_i.mul) begin
      prod_q <= {{pva_pkg::DutyW{1'b0}}, top_c} * {{TopW{1'b0}}, duty_q};
    end
    if (cmd_i.scale) begin
      cmp_q <= scaled[pva_pkg::RecipShift +: 16];
    end
    if (cmd_i.commit) begin
      accepted_o      <= found_q;
      voice_o         <= found_q ? 2'(idx_q) : 2'b00;
      period_top_o    <= start_ok ? top_c : '0;
      compare_value_o <= start_ok ? cmp_q : '0;
      run_o           <= start_ok;
      if (found_q) begin
        pitch_q[idx_q] <= start_ok ? hz_q : '0;
      end
    end
  end

endmodule

FILE: rtl/core/pwm_voice_allocator.sv
// Tone voice allocator for a bank of NUM_VOICES PWM voices.
// req_i carries one word per note event: opcode (start or stop), pitch_hz and
// duty_percent. rsp_o returns exactly one word per request: accepted, voice,
// period_top, compare_value and run.
// A start takes the lowest free voice and returns the counter top,
// 1000000 / pitch_hz saturated to 65535, and the compare value,
// floor(top * min(duty, 100) / 100). A stop frees the lowest busy voice
// holding the same pitch. Zero pitch, no free voice or no match give
// accepted 0 with all other fields 0.
// A start with a free voice passes through search, the bit-serial period
// divider, a multiply, a reciprocal scale and commit; other requests go
// through search and commit only. req_i.ready is high only when idle, which
// is the cycle after commit, so a new request is taken only once the last
// has committed. The response sits in an output register, so a new request
// is taken while the previous word waits; a stalled receiver holds the
// finished result of the next request until the register drains.
// Reset frees every voice and empties the output register.
`include "pwm_voice_allocator_assert.svh"

module pwm_voice_allocator #(
  parameter int NUM_VOICES = pva_pkg::NumVoices
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pva_req_if.sink   req_i,
  pva_rsp_if.source rsp_o
);

  pva_pkg::cmd_t cmd;
  pva_pkg::sts_t sts;

  pva_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pva_dp #(
    .NUM_VOICES (NUM_VOICES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (req_i.opcode),
    .pitch_hz_i      (req_i.pitch_hz),
    .duty_percent_i  (req_i.duty_percent),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .accepted_o      (rsp_o.accepted),
    .voice_o         (rsp_o.voice),
    .period_top_o    (rsp_o.period_top),
    .compare_value_o (rsp_o.compare_value),
    .run_o           (rsp_o.run)
  );

  `PVA_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd.commit, !rsp_o.valid || rsp_o.ready)
  `PVA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)
  `PVA_ASSERT_IMPLY(a_reject_zero, clk_i, rst_ni, rsp_o.valid && !rsp_o.accepted,
    rsp_o.period_top == 16'd0 && rsp_o.compare_value == 16'd0 && !rsp_o.run)
  `PVA_ASSERT_IMPLY(a_cmp_le_top, clk_i, rst_ni, rsp_o.valid && rsp_o.run,
    rsp_o.compare_value <= rsp_o.period_top && rsp_o.period_top != 16'd0)

endmodule

FILE: tb/sv/tb_pwm_voice_allocator.sv
`timescale 1ns / 100ps

module tb_pwm_voice_allocator;

  localparam int RandWords = 450;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic        accepted;
    logic [1:0]  voice;
    logic [15:0] period_top;
    logic [15:0] compare_value;
    logic        run;
  } tone_t;

  typedef struct packed {
    pva_pkg::op_e op;
    logic [15:0]  pitch;
    logic [7:0]   duty;
    logic         lit;
    tone_t        want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  pva_req_if req_if ();
  pva_rsp_if rsp_if ();

  pwm_voice_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Voice bank as the testbench sees it
  logic        bank_busy [pva_pkg::NumVoices];
  logic [15:0] bank_pitch[pva_pkg::NumVoices];

  tone_t    pending_tones[$];
  int       fail_cnt;
  logic     quiet;
  logic     hold_req;
  logic     hold_done;
  int       hold_left;
  logic [15:0] pitch_pool[6];
  dir_row_t dir_rows[22];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.opcode = pva_pkg::OpStart;
    req_if.pitch_hz = '0;
    req_if.duty_percent = '0;
    rsp_if.ready = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    fail_cnt = 0;
  end

  function automatic tone_t allocate_tone(input pva_pkg::op_e op, input logic [15:0] hz,
                                          input logic [7:0] duty);
    tone_t       res;
    int          hit;
    int unsigned top;
    int unsigned d;
    res = '0;
    hit = -1;
    if (hz == 16'd0) return res;
    if (op == pva_pkg::OpStart) begin
      for (int v = 0; v < pva_pkg::NumVoices; v++) begin
        if (hit < 0 && !bank_busy[v]) hit = v;
      end
      if (hit >= 0) begin
        top = 32'd1000000 / hz;
        if (top > 32'd65535) top = 32'd65535;
        d = (duty > 8'd100) ? 32'd100 : duty;
        bank_busy[hit] = 1'b1;
        bank_pitch[hit] = hz;
        res.accepted = 1'b1;
        res.voice = hit[1:0];
        res.period_top = top[15:0];
        res.compare_value = 16'((top * d) / 32'd100);
        res.run = 1'b1;
      end
    end else begin
      for (int v = 0; v < pva_pkg::NumVoices; v++) begin
        if (hit < 0 && bank_busy[v] && bank_pitch[v] == hz) hit = v;
      end
      if (hit >= 0) begin
        bank_busy[hit] = 1'b0;
        bank_pitch[hit] = '0;
        res.accepted = 1'b1;
        res.voice = hit[1:0];
      end
    end
    return res;
  endfunction

  // Drive one request word and return once it is taken
  task automatic send_req(input pva_pkg::op_e op, input logic [15:0] hz,
                          input logic [7:0] duty);
    while (!quiet && $urandom_range(0, 99) < 26) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.opcode <= op;
    req_if.pitch_hz <= hz;
    req_if.duty_percent <= duty;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  initial begin
    tone_t        want;
    pva_pkg::op_e op;
    logic [15:0]  hz;
    logic [7:0]   duty;
    logic [15:0]  busy_pitches[$];
    int           r;

    for (int v = 0; v < pva_pkg::NumVoices; v++) begin
      bank_busy[v] = 1'b0;
      bank_pitch[v] = '0;
    end
    for (int i = 0; i < 6; i++) pitch_pool[i] = 16'($urandom_range(16, 20000));

    dir_rows = '{
      '{pva_pkg::OpStart, 16'd0,     8'd50,  1'b1, '{1'b0, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStop,  16'd0,     8'd0,   1'b1, '{1'b0, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStop,  16'd1000,  8'd0,   1'b1, '{1'b0, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStart, 16'd1,     8'd255, 1'b1, '{1'b1, 2'd0, 16'd65535, 16'd65535, 1'b1}},
      '{pva_pkg::OpStart, 16'd65535, 8'd0,   1'b1, '{1'b1, 2'd1, 16'd15,    16'd0,     1'b1}},
      '{pva_pkg::OpStart, 16'd15,    8'd50,  1'b1, '{1'b1, 2'd2, 16'd65535, 16'd32767, 1'b1}},
      '{pva_pkg::OpStart, 16'd16,    8'd100, 1'b1, '{1'b1, 2'd3, 16'd62500, 16'd62500, 1'b1}},
      '{pva_pkg::OpStart, 16'd440,   8'd30,  1'b1, '{1'b0, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStop,  16'd65535, 8'd0,   1'b1, '{1'b1, 2'd1, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStart, 16'd440,   8'd101, 1'b0, '0},
      '{pva_pkg::OpStop,  16'd1,     8'd0,   1'b1, '{1'b1, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStart, 16'd440,   8'd37,  1'b0, '0},
      '{pva_pkg::OpStop,  16'd440,   8'd0,   1'b0, '0},
      '{pva_pkg::OpStop,  16'd440,   8'd0,   1'b0, '0},
      '{pva_pkg::OpStop,  16'd440,   8'd0,   1'b1, '{1'b0, 2'd0, 16'd0,     16'd0,     1'b0}},
      '{pva_pkg::OpStart, 16'd1000,  8'd128, 1'b0, '0},
      '{pva_pkg::OpStart, 16'hAAAA,  8'h55,  1'b0, '0},
      '{pva_pkg::OpStart, 16'h5555,  8'h2A,  1'b0, '0},
      '{pva_pkg::OpStop,  16'd15,    8'd0,   1'b0, '0},
      '{pva_pkg::OpStop,  16'd16,    8'd0,   1'b0, '0},
      '{pva_pkg::OpStop,  16'd1000,  8'd0,   1'b0, '0},
      '{pva_pkg::OpStop,  16'hAAAA,  8'd0,   1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].op, dir_rows[i].pitch, dir_rows[i].duty);
      want = allocate_tone(dir_rows[i].op, dir_rows[i].pitch, dir_rows[i].duty);
      pending_tones.push_back(dir_rows[i].lit ? dir_rows[i].want : want);
    end

    for (int n = 0; n < RandWords; n++) begin
      if (n == 150) quiet <= 1'b1;
      if (n == 250) quiet <= 1'b0;
      if (n == 300) hold_req <= 1'b1;

      busy_pitches.delete();
      for (int v = 0; v < pva_pkg::NumVoices; v++) begin
        if (bank_busy[v]) busy_pitches.push_back(bank_pitch[v]);
      end

      op = ($urandom_range(0, 99) < 50) ? pva_pkg::OpStop : pva_pkg::OpStart;
      r = $urandom_range(0, 99);
      if (op == pva_pkg::OpStart) begin
        if (r < 8) hz = '0;
        else if (r < 22) hz = 16'($urandom_range(1, 15));
        else if (r < 45) hz = 16'($urandom);
        else hz = pitch_pool[$urandom_range(0, 5)];
      end else begin
        if (r < 70 && busy_pitches.size() != 0)
          hz = busy_pitches[$urandom_range(0, busy_pitches.size() - 1)];
        else if (r < 85) hz = pitch_pool[$urandom_range(0, 5)];
        else if (r < 90) hz = '0;
        else hz = 16'($urandom);
      end
      duty = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 100)) : 8'($urandom);

      send_req(op, hz, duty);
      pending_tones.push_back(allocate_tone(op, hz, duty));
    end
    req_if.valid <= 1'b0;

    while (pending_tones.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back up the block
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      rsp_if.ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      rsp_if.ready <= quiet || ($urandom_range(0, 99) >= 26);
    end
  end

  always @(posedge clk_i) begin : check_words
    tone_t got;
    tone_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{rsp_if.accepted, rsp_if.voice, rsp_if.period_top,
              rsp_if.compare_value, rsp_if.run};
      if (pending_tones.size() == 0) begin
        $error("response word with no request pending");
        fail_cnt++;
      end else begin
        want = pending_tones.pop_front();
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          fail_cnt++;
        end
        if (got.voice !== want.voice) begin
          $error("voice: expected %0d, got %0d", want.voice, got.voice);
          fail_cnt++;
        end
        if (got.period_top !== want.period_top) begin
          $error("period_top: expected %0d, got %0d", want.period_top, got.period_top);
          fail_cnt++;
        end
        if (got.compare_value !== want.compare_value) begin
          $error("compare_value: expected %0d, got %0d",
                 want.compare_value, got.compare_value);
          fail_cnt++;
        end
        if (got.run !== want.run) begin
          $error("run: expected %0d, got %0d", want.run, got.run);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
